// ----- rtl/core/mtrc_pkg.sv -----
// Shared types and constants for the Modbus TCP read response checker.
`timescale 1ns / 1ps

package mtrc_pkg;

  localparam int UNIT_W     = 8;
  localparam int FUNC_W     = 3;
  localparam int QTY_W      = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int POS_W      = 9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTITY = 2'd2;

  // Reset values of the configuration registers
  localparam logic [UNIT_W-1:0] UNIT_RESET     = 8'd0;
  localparam logic [FUNC_W-1:0] FUNCTION_RESET = 3'd3;
  localparam logic [QTY_W-1:0]  QUANTITY_RESET = 11'd1;

  // Function codes
  localparam logic [FUNC_W-1:0] FN_COILS    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DISCRETE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_INPUT    = 3'd4;

  // Byte positions within the frame
  localparam logic [POS_W-1:0] POS_PROTO_HI  = 9'd2;
  localparam logic [POS_W-1:0] POS_PROTO_LO  = 9'd3;
  localparam logic [POS_W-1:0] POS_LENGTH_HI = 9'd4;
  localparam logic [POS_W-1:0] POS_LENGTH_LO = 9'd5;
  localparam logic [POS_W-1:0] POS_UNIT      = 9'd6;
  localparam logic [POS_W-1:0] POS_FUNCTION  = 9'd7;
  localparam logic [POS_W-1:0] POS_COUNT     = 9'd8;
  localparam logic [POS_W-1:0] POS_DATA      = 9'd9;
  localparam logic [POS_W-1:0] POS_MAX       = 9'd511;

  localparam logic [15:0] PDU_OVERHEAD = 16'd3;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PROTOCOL   = 3'd1,
    ST_LENGTH     = 3'd2,
    ST_UNIT       = 3'd3,
    ST_FUNCTION   = 3'd4,
    ST_BYTE_COUNT = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    logic [15:0] data_value;
    logic [7:0]  item_index;
    status_t     status;
    logic        last;
  } out_req_t;

  typedef struct packed {
    logic [UNIT_W-1:0] expected_unit;
    logic [FUNC_W-1:0] expected_function;
    logic [QTY_W-1:0]  expected_quantity;
  } cfg_t;

endpackage

// ----- rtl/core/modbus_tcp_read_response_checker.sv -----
// Top level of the Modbus TCP read response checker.
`timescale 1ns / 1ps

// Feed the bytes of one Modbus TCP read response, one request per byte, with
// frame_start set on the first header byte. The header (MBAP plus function
// code) is captured; on the byte count byte the checks run in order:
// protocol id, length, unit id, function code, byte count. The first
// failure gives a single error result with last set and the rest of the
// frame is dropped until the next frame_start. Otherwise data results
// follow: one packed byte per result for functions 1 and 2, one big-endian
// word per two bytes for functions 3 and 4, the final one marked last.
// Throughput is one byte per cycle while in_stall is low: each byte is handled
// in a single pass of compare and counter logic, and its result is registered
// into a two-entry output queue. in_stall rises only when both queue slots hold
// results that the downstream side has not taken. Write configuration only
// while no frame is in progress and the output is drained.

module modbus_tcp_read_response_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mtrc_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mtrc_pkg::out_req_t                  out_data,
  input  logic                                cfg_write,
  input  logic [mtrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mtrc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mtrc_pkg::*;

  cfg_t     cfg;
  logic     take;
  logic     res_valid;
  out_req_t res;
  logic     queue_full;

  // Configuration registers; writes to unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_unit     <= UNIT_RESET;
      cfg.expected_function <= FUNCTION_RESET;
      cfg.expected_quantity <= QUANTITY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_UNIT:     cfg.expected_unit     <= cfg_data[UNIT_W-1:0];
        REG_FUNCTION: cfg.expected_function <= cfg_data[FUNC_W-1:0];
        REG_QUANTITY: cfg.expected_quantity <= cfg_data[QTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold off the sender only when no queue slot is free.
  assign in_stall = queue_full;
  assign take     = in_valid && !in_stall;

  mtrc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_req    (in_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  mtrc_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/mtrc_parser.sv -----
// Frame state, header checks and data packing for one received byte.
`timescale 1ns / 1ps

module mtrc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  mtrc_pkg::in_req_t in_req,
  input  mtrc_pkg::cfg_t    cfg,
  output logic              res_valid,
  output mtrc_pkg::out_req_t res
);
  import mtrc_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next, pos_cur;
  logic             protocol_nonzero, protocol_nonzero_next, pn_cur;
  logic [15:0]      length_word, length_word_next, len_cur;
  logic [7:0]       seen_unit, seen_unit_next, unit_cur;
  logic [7:0]       seen_function, seen_function_next, func_cur;
  logic [7:0]       high_byte_hold, high_byte_hold_next, hold_cur;
  logic [7:0]       data_index, data_index_next, idx_cur;
  logic             frame_done, frame_done_next, done_cur;

  logic [7:0]       b;
  logic [11:0]      q_plus7;
  logic [11:0]      want;
  logic             fn_ok;
  status_t          chk;
  logic [7:0]       count;
  logic [POS_W-1:0] off;
  logic             is_last;

  assign b = in_req.rx_byte;

  always_comb begin
    // frame start wipes the frame state before the byte is looked at
    pos_cur  = in_req.frame_start ? '0 : byte_position;
    pn_cur   = in_req.frame_start ? 1'b0 : protocol_nonzero;
    len_cur  = in_req.frame_start ? '0 : length_word;
    unit_cur = in_req.frame_start ? '0 : seen_unit;
    func_cur = in_req.frame_start ? '0 : seen_function;
    hold_cur = in_req.frame_start ? '0 : high_byte_hold;
    idx_cur  = in_req.frame_start ? '0 : data_index;
    done_cur = in_req.frame_start ? 1'b0 : frame_done;

    q_plus7 = {1'b0, cfg.expected_quantity} + 12'd7;
    want    = (cfg.expected_function <= FN_DISCRETE) ? {3'b000, q_plus7[11:3]}
                                                     : {cfg.expected_quantity, 1'b0};
    fn_ok   = (cfg.expected_function >= FN_COILS) && (cfg.expected_function <= FN_INPUT) &&
              (func_cur == {5'b00000, cfg.expected_function});

    if (pn_cur) begin
      chk = ST_PROTOCOL;
    end else if (len_cur != (PDU_OVERHEAD + {8'h00, b})) begin
      chk = ST_LENGTH;
    end else if (unit_cur != cfg.expected_unit) begin
      chk = ST_UNIT;
    end else if (!fn_ok) begin
      chk = ST_FUNCTION;
    end else if ({4'h0, b} != want) begin
      chk = ST_BYTE_COUNT;
    end else begin
      chk = ST_OK;
    end

    count   = len_cur[7:0] - PDU_OVERHEAD[7:0];
    off     = pos_cur - POS_DATA;
    is_last = ({1'b0, off} + 10'd1) == {2'b00, count};

    byte_position_next    = byte_position;
    protocol_nonzero_next = protocol_nonzero;
    length_word_next      = length_word;
    seen_unit_next        = seen_unit;
    seen_function_next    = seen_function;
    high_byte_hold_next   = high_byte_hold;
    data_index_next       = data_index;
    frame_done_next       = frame_done;
    res_valid             = 1'b0;
    res                   = '0;

    if (take) begin
      byte_position_next    = pos_cur;
      protocol_nonzero_next = pn_cur;
      length_word_next      = len_cur;
      seen_unit_next        = unit_cur;
      seen_function_next    = func_cur;
      high_byte_hold_next   = hold_cur;
      data_index_next       = idx_cur;
      frame_done_next       = done_cur;

      if (!done_cur) begin
        if (pos_cur < POS_COUNT) begin
          if ((pos_cur == POS_PROTO_HI) || (pos_cur == POS_PROTO_LO)) begin
            if (b != 8'h00) begin
              protocol_nonzero_next = 1'b1;
            end
          end else if (pos_cur == POS_LENGTH_HI) begin
            length_word_next = {b, len_cur[7:0]};
          end else if (pos_cur == POS_LENGTH_LO) begin
            length_word_next = {len_cur[15:8], b};
          end else if (pos_cur == POS_UNIT) begin
            seen_unit_next = b;
          end else if (pos_cur == POS_FUNCTION) begin
            seen_function_next = b;
          end
          byte_position_next = pos_cur + 9'd1;
        end else if (pos_cur == POS_COUNT) begin
          if ((chk != ST_OK) || (b == 8'h00)) begin
            res_valid       = 1'b1;
            res.status      = chk;
            res.last        = 1'b1;
            frame_done_next = 1'b1;
          end else begin
            byte_position_next = POS_DATA;
          end
        end else begin
          if (func_cur <= {5'b00000, FN_DISCRETE}) begin
            res_valid       = 1'b1;
            res.data_value  = {8'h00, b};
            res.item_index  = idx_cur;
            res.last        = is_last;
            data_index_next = idx_cur + 8'd1;
          end else if (!off[0]) begin
            high_byte_hold_next = b;
          end else begin
            res_valid       = 1'b1;
            res.data_value  = {hold_cur, b};
            res.item_index  = idx_cur;
            res.last        = is_last;
            data_index_next = idx_cur + 8'd1;
          end
          if (is_last) begin
            frame_done_next = 1'b1;
          end
          if (pos_cur < POS_MAX) begin
            byte_position_next = pos_cur + 9'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      protocol_nonzero <= 1'b0;
      length_word      <= '0;
      seen_unit        <= '0;
      seen_function    <= '0;
      high_byte_hold   <= '0;
      data_index       <= '0;
      frame_done       <= 1'b1;
    end else begin
      byte_position    <= byte_position_next;
      protocol_nonzero <= protocol_nonzero_next;
      length_word      <= length_word_next;
      seen_unit        <= seen_unit_next;
      seen_function    <= seen_function_next;
      high_byte_hold   <= high_byte_hold_next;
      data_index       <= data_index_next;
      frame_done       <= frame_done_next;
    end
  end

endmodule

// ----- rtl/core/mtrc_out_queue.sv -----
// Two-entry result queue: two slots addressed by read and write pointers.
`timescale 1ns / 1ps

module mtrc_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mtrc_pkg::out_req_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output mtrc_pkg::out_req_t out_data
);
  import mtrc_pkg::*;

  out_req_t    slots [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  fill, fill_next;
  logic        pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (fill != 2'd0);
  assign full      = (fill == 2'd2);
  assign out_data  = slots[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + 2'd1;
    end else if (pop && !push) begin
      fill_next = fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

endmodule
